// ===== hw/rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver package
// Shared result codes, sync constant and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int unsigned IDX_W = 4;

  typedef enum logic [1:0] {
    ST_PARAM     = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_CSUM_ERR  = 2'd2,
    ST_LEN_ERR   = 2'd3
  } status_e;

  typedef struct packed {
    logic cap_first;
    logic cap_type;
    logic cap_len;
    logic cap_param;
    logic emit_len_err;
    logic emit_csum_err;
    logic emit_empty;
    logic start_dump;
    logic emit_param;
  } cmd_t;

  typedef struct packed {
    logic sync_ok;
    logic len_over;
    logic len_in_zero;
    logic len_q_zero;
    logic param_done;
    logic csum_ok;
    logic dump_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/cfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver controller
// Frame state machine that sequences the datapath and drives input ready.
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfr_pkg::sts_t sts_i,
  output cfr_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_SYNC0 = 7'b0000001,
    S_SYNC1 = 7'b0000010,
    S_TYPE  = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_PARAM = 7'b0010000,
    S_CSUM  = 7'b0100000,
    S_DUMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    unique case (state_q)
      S_LEN, S_CSUM: in_ready_o = sts_i.out_free;
      S_DUMP:        in_ready_o = 1'b0;
      default:       in_ready_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SYNC0: begin
        if (accept) begin
          cmd_o.cap_first = 1'b1;
          state_d = S_SYNC1;
        end
      end
      S_SYNC1: begin
        if (accept) begin
          state_d = sts_i.sync_ok ? S_TYPE : S_SYNC0;
        end
      end
      S_TYPE: begin
        if (accept) begin
          cmd_o.cap_type = 1'b1;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          if (sts_i.len_over) begin
            cmd_o.emit_len_err = 1'b1;
            state_d = S_SYNC0;
          end else begin
            cmd_o.cap_len = 1'b1;
            state_d = sts_i.len_in_zero ? S_CSUM : S_PARAM;
          end
        end
      end
      S_PARAM: begin
        if (accept) begin
          cmd_o.cap_param = 1'b1;
          if (sts_i.param_done) begin
            state_d = S_CSUM;
          end
        end
      end
      S_CSUM: begin
        if (accept) begin
          priority if (!sts_i.csum_ok) begin
            cmd_o.emit_csum_err = 1'b1;
            state_d = S_SYNC0;
          end else if (sts_i.len_q_zero) begin
            cmd_o.emit_empty = 1'b1;
            state_d = S_SYNC0;
          end else begin
            cmd_o.start_dump = 1'b1;
            state_d = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_param = 1'b1;
          if (sts_i.dump_done) begin
            state_d = S_SYNC0;
          end
        end
      end
      default: state_d = S_SYNC0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SYNC0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/cfr_dpath.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver datapath
// Frame registers, running sum, parameter memory and the result register.
// ----------------------------------------------------------------------------
module cfr_dpath #(
  parameter int unsigned Depth = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    rx_byte_i,
  input  cfr_pkg::cmd_t cmd_i,
  output cfr_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [7:0]    frame_type_o,
  output logic [7:0]    frame_length_o,
  output logic [3:0]    param_index_o,
  output logic [7:0]    param_value_o,
  output logic          last_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [7:0] LenLimit = 8'(Depth);

  logic [7:0]       first_sync_q;
  logic [7:0]       type_q;
  logic [7:0]       length_q;
  logic [7:0]       sum_q;
  logic [AddrW-1:0] pos_q;
  logic [7:0]       mem_q [Depth];

  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [7:0]       out_type_q;
  logic [7:0]       out_length_q;
  logic [3:0]       out_index_q;
  logic [7:0]       out_value_q;
  logic             out_last_q;

  logic             emit_any;
  logic             emit_single;
  logic             pos_is_end;

  assign emit_single = cmd_i.emit_len_err || cmd_i.emit_csum_err || cmd_i.emit_empty;
  assign emit_any    = emit_single || cmd_i.emit_param;
  assign pos_is_end  = (8'(pos_q) == (length_q - 8'd1));

  assign sts_o.sync_ok     = (first_sync_q == cfr_pkg::SYNC_BYTE) &&
                             (rx_byte_i == cfr_pkg::SYNC_BYTE);
  assign sts_o.len_over    = (rx_byte_i > LenLimit);
  assign sts_o.len_in_zero = (rx_byte_i == 8'd0);
  assign sts_o.len_q_zero  = (length_q == 8'd0);
  assign sts_o.param_done  = pos_is_end;
  assign sts_o.csum_ok     = (~sum_q == rx_byte_i);
  assign sts_o.dump_done   = pos_is_end;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q <= '0;
      type_q       <= '0;
      length_q     <= '0;
      sum_q        <= '0;
      pos_q        <= '0;
    end else begin
      if (cmd_i.cap_first) begin
        first_sync_q <= rx_byte_i;
      end
      if (cmd_i.cap_type) begin
        type_q <= rx_byte_i;
      end
      if (cmd_i.emit_len_err) begin
        length_q <= '0;
      end else if (cmd_i.cap_len) begin
        length_q <= rx_byte_i;
      end
      if (cmd_i.cap_len) begin
        sum_q <= type_q + rx_byte_i;
      end else if (cmd_i.cap_param) begin
        sum_q <= sum_q + rx_byte_i;
      end
      if (cmd_i.cap_len || cmd_i.start_dump) begin
        pos_q <= '0;
      end else if (cmd_i.cap_param || cmd_i.emit_param) begin
        pos_q <= pos_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_param) begin
      mem_q[pos_q] <= rx_byte_i;
    end
    if (cmd_i.emit_param) begin
      out_value_q <= mem_q[pos_q];
    end else if (emit_single) begin
      out_value_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_type_q <= type_q;
      unique case (1'b1)
        cmd_i.emit_len_err: begin
          out_status_q <= cfr_pkg::ST_LEN_ERR;
          out_length_q <= rx_byte_i;
          out_index_q  <= '0;
          out_last_q   <= 1'b1;
        end
        cmd_i.emit_csum_err: begin
          out_status_q <= cfr_pkg::ST_CSUM_ERR;
          out_length_q <= length_q;
          out_index_q  <= '0;
          out_last_q   <= 1'b1;
        end
        cmd_i.emit_empty: begin
          out_status_q <= cfr_pkg::ST_EMPTY;
          out_length_q <= 8'd0;
          out_index_q  <= '0;
          out_last_q   <= 1'b1;
        end
        default: begin
          out_status_q <= cfr_pkg::ST_PARAM;
          out_length_q <= length_q;
          out_index_q  <= cfr_pkg::IDX_W'(pos_q);
          out_last_q   <= pos_is_end;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_type_o   = out_type_q;
  assign frame_length_o = out_length_q;
  assign param_index_o  = out_index_q;
  assign param_value_o  = out_value_q;
  assign last_o         = out_last_q;

endmodule

// ===== hw/rtl/checksummed_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver
// Parses sync, type, length, parameter and checksum bytes into result items.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   input     in_valid_i/in_ready_o   rx_byte_i
//   output    out_valid_o/out_ready_i status_o, frame_type_o, frame_length_o,
//                                     param_index_o, param_value_o, last_o
//
// Header and parameter bytes are taken one per cycle. A length or checksum
// byte waits only while the result register is full and not being drained.
// After a good frame the parameter memory is read out one result per cycle
// while the result register is free, and input is held off until the last
// parameter is out. Reset returns the receiver to hunting for a sync pair;
// the memory needs no clearing.
module checksummed_frame_receiver_unit #(
  parameter int unsigned MAX_PARAM_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] frame_type_o,
  output logic [7:0] frame_length_o,
  output logic [3:0] param_index_o,
  output logic [7:0] param_value_o,
  output logic       last_o
);

  localparam int unsigned StoreDepth = 16;
  localparam int unsigned Limit =
    (MAX_PARAM_BYTES > StoreDepth) ? StoreDepth : MAX_PARAM_BYTES;

  cfr_pkg::cmd_t cmd;
  cfr_pkg::sts_t sts;

  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfr_dpath #(
    .Depth (Limit)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_type_o   (frame_type_o),
    .frame_length_o (frame_length_o),
    .param_index_o  (param_index_o),
    .param_value_o  (param_value_o),
    .last_o         (last_o)
  );

endmodule
